/* rtl/core/vgp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgp_pkg
// Shared widths, register codes, stage payload types and mask helpers of the
// vertical gradient pixel pipeline.
// ----------------------------------------------------------------------------
package vgp_pkg;

   localparam int CHAN_W             = 8;
   localparam int HEIGHT_W           = 13;
   localparam int ROW_W              = 12;
   localparam int SUM_W              = HEIGHT_W + CHAN_W;
   localparam int DIVISOR_W          = HEIGHT_W + CHAN_W - 1;
   localparam int WORD_W             = 32;
   localparam int SHIFT_W            = $clog2(WORD_W);
   localparam int COUNT_W            = $clog2(WORD_W + 1);
   localparam int FRAC_W             = 3;
   localparam int SMALL_W            = 16;
   localparam int CHANNELS           = 3;
   localparam int ADDR_W             = 4;
   localparam int MAX_HEIGHT_DEFAULT = 4096;

   localparam logic [WORD_W-1:0] RED_MASK_RESET   = 32'h00FF_0000;
   localparam logic [WORD_W-1:0] GREEN_MASK_RESET = 32'h0000_FF00;
   localparam logic [WORD_W-1:0] BLUE_MASK_RESET  = 32'h0000_00FF;

   typedef enum logic [1:0] {
      REG_RED   = 2'd0,
      REG_GREEN = 2'd1,
      REG_BLUE  = 2'd2
   } reg_index_type;

   // Division stage payload: one remainder and partial quotient per channel
   typedef struct packed {
      logic [CHANNELS-1:0][SUM_W-1:0]  rem;
      logic [CHANNELS-1:0][CHAN_W-1:0] quot;
      logic [DIVISOR_W-1:0]            divisor;
      logic                            past;
      logic [CHANNELS-1:0][CHAN_W-1:0] bottom;
   } div_type;

   // Scale terms derived from a channel mask.
   // 2^n = 255 * whole + 2^frac, so (v*(2^n-1)+127)/255 =
   // v*whole + (v*(2^frac-1)+127)/255.
   typedef struct packed {
      logic [SHIFT_W-1:0] shift;
      logic [FRAC_W-1:0]  frac;
      logic [WORD_W-1:0]  whole;
   } scale_type;

   function automatic logic [COUNT_W-1:0] count_ones(input logic [WORD_W-1:0] m);
      logic [COUNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < WORD_W; i++) begin
         n = n + COUNT_W'(m[i]);
      end
      return n;
   endfunction

   function automatic logic [SHIFT_W-1:0] lowest_one(input logic [WORD_W-1:0] m);
      logic [SHIFT_W-1:0] s;
      s = '0;
      for (int i = WORD_W - 1; i >= 0; i--) begin
         if (m[i]) begin
            s = SHIFT_W'(i);
         end
      end
      return s;
   endfunction

   function automatic scale_type mask_scale(input logic [WORD_W-1:0] m);
      scale_type          s;
      logic [COUNT_W-1:0] n;
      logic [WORD_W-1:0]  bytes;
      n     = count_ones(m);
      bytes = '0;
      // (2^(8k)-1)/255 is k bytes of 0x01
      for (int i = 0; i < WORD_W / CHAN_W; i++) begin
         if (3'(i) < n[COUNT_W-1:FRAC_W]) begin
            bytes[CHAN_W*i +: CHAN_W] = 8'h01;
         end
      end
      s.frac  = n[FRAC_W-1:0];
      s.whole = bytes << n[FRAC_W-1:0];
      s.shift = lowest_one(m);
      return s;
   endfunction

endpackage

/* rtl/core/vgp_req_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgp_req_if
// Request channel: two colours, gradient height and row index.
// ----------------------------------------------------------------------------
interface vgp_req_if import vgp_pkg::*; ();

   logic                valid;
   logic                ready;
   logic [CHAN_W-1:0]   top_red;
   logic [CHAN_W-1:0]   top_green;
   logic [CHAN_W-1:0]   top_blue;
   logic [CHAN_W-1:0]   bottom_red;
   logic [CHAN_W-1:0]   bottom_green;
   logic [CHAN_W-1:0]   bottom_blue;
   logic [HEIGHT_W-1:0] height;
   logic [ROW_W-1:0]    row;

   modport source (
      output valid, top_red, top_green, top_blue,
      output bottom_red, bottom_green, bottom_blue, height, row,
      input  ready
   );

   modport sink (
      input  valid, top_red, top_green, top_blue,
      input  bottom_red, bottom_green, bottom_blue, height, row,
      output ready
   );

endinterface

/* rtl/core/vgp_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgp_rsp_if
// Response channel: packed pixel word and the blended channel bytes.
// ----------------------------------------------------------------------------
interface vgp_rsp_if import vgp_pkg::*; ();

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] pixel;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (
      output valid, pixel, red, green, blue,
      input  ready
   );

   modport sink (
      input  valid, pixel, red, green, blue,
      output ready
   );

endinterface

/* rtl/core/vertical_gradient_pixel_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertical_gradient_pixel_top
// Blends a top and a bottom colour for one gradient row and packs the result
// into a display pixel word through three programmable channel masks.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries the two colours, the gradient height and the row; one
//   transfer gives exactly one rsp_chan transfer, in order.
//   The csr port holds the red, green and blue masks at byte addresses 0, 4
//   and 8; write them only while no request is in flight.
// Timing:
//   Seven register stages lie between a request transfer and its response:
//   one stage forms the weighted sums, four divider stages take two
//   quotient bits each, one stage forms the scale products and one registers
//   the packed pixel.
//   A new request is taken every cycle unless the output stalls; the eight-bit
//   restoring divider is spread over four stages.
// Reset:
//   Clears every stage valid bit and loads the masks with 0x00FF0000,
//   0x0000FF00 and 0x000000FF.
// Backpressure:
//   Each stage holds when the one after it is full and stalled; empty stages
//   still fill, so requests are taken until the whole pipeline is full.
// ----------------------------------------------------------------------------
module vertical_gradient_pixel_top import vgp_pkg::*; #(
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   vgp_req_if.sink           req_chan,
   vgp_rsp_if.source         rsp_chan,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [WORD_W-1:0] csr_pwdata,
   output logic [WORD_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int HEIGHT_TOP = (1 << HEIGHT_W) - 1;
   localparam int LIMIT      = (MAX_HEIGHT < HEIGHT_TOP) ? MAX_HEIGHT : HEIGHT_TOP;
   localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = HEIGHT_W'(LIMIT);
   localparam int DIV_STAGES = CHAN_W / 2;

   // ---------------------------------------------------------------- config
   logic      [WORD_W-1:0] mask_ff  [CHANNELS];
   scale_type              scale_ff [CHANNELS];
   logic                   csr_write;
   logic      [1:0]        csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff[REG_RED]   <= RED_MASK_RESET;
         mask_ff[REG_GREEN] <= GREEN_MASK_RESET;
         mask_ff[REG_BLUE]  <= BLUE_MASK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_RED:   mask_ff[REG_RED]   <= csr_pwdata;
            REG_GREEN: mask_ff[REG_GREEN] <= csr_pwdata;
            REG_BLUE:  mask_ff[REG_BLUE]  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_RED:   csr_prdata = mask_ff[REG_RED];
         REG_GREEN: csr_prdata = mask_ff[REG_GREEN];
         REG_BLUE:  csr_prdata = mask_ff[REG_BLUE];
         default:   csr_prdata = '0;
      endcase
   end

   // Scale terms are registered from the masks
   always_ff @(posedge clock) begin
      for (int c = 0; c < CHANNELS; c++) begin
         scale_ff[c] <= mask_scale(mask_ff[c]);
      end
   end

   // ------------------------------------------------------ stage 1: sums
   logic                            s1_valid_ff;
   div_type                         s1_data_ff;
   div_type                         s1_data_in;
   logic                            s1_ready;
   logic [HEIGHT_W-1:0]             height_clamp;
   logic [HEIGHT_W-1:0]             span;
   logic [CHANNELS-1:0][CHAN_W-1:0] top_colour;

   always_comb begin
      height_clamp = (req_chan.height > HEIGHT_LIMIT) ? HEIGHT_LIMIT : req_chan.height;
      span         = height_clamp - {1'b0, req_chan.row};
      top_colour[REG_RED]        = req_chan.top_red;
      top_colour[REG_GREEN]      = req_chan.top_green;
      top_colour[REG_BLUE]       = req_chan.top_blue;
      s1_data_in.bottom[REG_RED]   = req_chan.bottom_red;
      s1_data_in.bottom[REG_GREEN] = req_chan.bottom_green;
      s1_data_in.bottom[REG_BLUE]  = req_chan.bottom_blue;
      s1_data_in.past    = ({1'b0, req_chan.row} >= height_clamp);
      s1_data_in.divisor = {height_clamp, {(CHAN_W - 1){1'b0}}};
      s1_data_in.quot    = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         s1_data_in.rem[c] = SUM_W'(top_colour[c]) * SUM_W'(span)
                           + SUM_W'(s1_data_in.bottom[c]) * SUM_W'(req_chan.row);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_chan.valid) begin
         s1_data_ff <= s1_data_in;
      end
   end

   assign req_chan.ready = s1_ready;

   // --------------------------------------------------- divider stages
   logic    stage_valid [DIV_STAGES + 1];
   logic    stage_ready [DIV_STAGES + 1];
   div_type stage_data  [DIV_STAGES + 1];

   assign stage_valid[0] = s1_valid_ff;
   assign stage_data[0]  = s1_data_ff;
   assign s1_ready       = !s1_valid_ff || stage_ready[0];

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      vgp_div_stage u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g + 1]),
         .out_ready (stage_ready[g + 1]),
         .out_data  (stage_data[g + 1])
      );
   end

   // ------------------------------------------- scale products stage
   logic                                 k1_valid_ff;
   logic                                 k1_ready;
   logic [CHANNELS-1:0][CHAN_W-1:0]      k1_colour_ff;
   logic [CHANNELS-1:0][WORD_W-1:0]      k1_whole_ff;
   logic [CHANNELS-1:0][SMALL_W-1:0]     k1_frac_ff;
   logic [CHANNELS-1:0][CHAN_W-1:0]      k1_colour_in;
   logic [CHANNELS-1:0][WORD_W-1:0]      k1_whole_in;
   logic [CHANNELS-1:0][SMALL_W-1:0]     k1_frac_in;
   logic                                 out_ready;

   always_comb begin
      for (int c = 0; c < CHANNELS; c++) begin
         k1_colour_in[c] = stage_data[DIV_STAGES].past ? stage_data[DIV_STAGES].bottom[c]
                                                       : stage_data[DIV_STAGES].quot[c];
         k1_whole_in[c]  = WORD_W'(k1_colour_in[c]) * scale_ff[c].whole;
         k1_frac_in[c]   = SMALL_W'(k1_colour_in[c])
                         * ((SMALL_W'(1) << scale_ff[c].frac) - SMALL_W'(1))
                         + SMALL_W'(127);
      end
   end

   assign k1_ready               = !k1_valid_ff || out_ready;
   assign stage_ready[DIV_STAGES] = k1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         k1_valid_ff <= 1'b0;
      end else if (k1_ready) begin
         k1_valid_ff <= stage_valid[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (k1_ready && stage_valid[DIV_STAGES]) begin
         k1_colour_ff <= k1_colour_in;
         k1_whole_ff  <= k1_whole_in;
         k1_frac_ff   <= k1_frac_in;
      end
   end

   // ------------------------------------------------- output stage
   logic                             out_valid_ff;
   logic [WORD_W-1:0]                pixel_ff;
   logic [CHANNELS-1:0][CHAN_W-1:0]  colour_ff;
   logic [WORD_W-1:0]                pixel_in;
   logic [SMALL_W-1:0]               frac_quot;
   logic [WORD_W-1:0]                scaled;

   always_comb begin
      pixel_in  = '0;
      frac_quot = '0;
      scaled    = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         // exact floor(y/255) for y up to 255*127+127
         frac_quot = (k1_frac_ff[c] + SMALL_W'(1) + (k1_frac_ff[c] >> CHAN_W)) >> CHAN_W;
         scaled    = k1_whole_ff[c] + WORD_W'(frac_quot);
         pixel_in  = pixel_in | ((scaled << scale_ff[c].shift) & mask_ff[c]);
      end
   end

   assign out_ready = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= k1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && k1_valid_ff) begin
         pixel_ff  <= pixel_in;
         colour_ff <= k1_colour_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.pixel = pixel_ff;
   assign rsp_chan.red   = colour_ff[REG_RED];
   assign rsp_chan.green = colour_ff[REG_GREEN];
   assign rsp_chan.blue  = colour_ff[REG_BLUE];

   // ---------------------------------------------------- assertions
   // Input held off only when every stage is full down to a stalled output
   assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("request stalled while pipeline has room");

   // An accepted request lands in the first stage
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> s1_valid_ff)
      else $error("accepted request lost at first stage");

   // A new response comes only from a valid product stage
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(k1_valid_ff))
      else $error("response raised without a product stage item");

endmodule

/* rtl/core/vgp_div_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vgp_div_stage
// One registered step of the restoring divider: two quotient bits for each
// of the three channels, with its own valid bit and backpressure.
// ----------------------------------------------------------------------------
module vgp_div_stage import vgp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic                 valid_ff;
   div_type              data_ff;
   div_type              data_in;
   logic [DIVISOR_W-1:0] divisor;

   always_comb begin
      data_in = in_data;
      divisor = in_data.divisor;
      for (int s = 0; s < 2; s++) begin
         for (int c = 0; c < CHANNELS; c++) begin
            if (data_in.rem[c] >= SUM_W'(divisor)) begin
               data_in.rem[c]  = data_in.rem[c] - SUM_W'(divisor);
               data_in.quot[c] = {data_in.quot[c][CHAN_W-2:0], 1'b1};
            end else begin
               data_in.quot[c] = {data_in.quot[c][CHAN_W-2:0], 1'b0};
            end
         end
         divisor = divisor >> 1;
      end
      data_in.divisor = divisor;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
